>>> rtl/bpe_pkg.sv
package bpe_pkg;

    typedef enum logic [1:0] {
        SCH_PKCS7 = 2'd0,
        SCH_X923  = 2'd1,
        SCH_ISO   = 2'd2,
        SCH_ESP   = 2'd3
    } t_scheme;

    typedef enum logic {
        DIR_PAD   = 1'b0,
        DIR_UNPAD = 1'b1
    } t_dir;

    typedef enum logic [1:0] {
        REG_SCHEME     = 2'd0,
        REG_DIRECTION  = 2'd1,
        REG_BLOCK_SIZE = 2'd2
    } t_reg_idx;

    localparam logic [7:0] MARK_BYTE      = 8'h80;
    localparam logic [7:0] ONE_BYTE       = 8'h01;
    localparam logic [7:0] MIN_BLOCK      = 8'd3;
    localparam logic [7:0] BLOCK_SIZE_RST = 8'd16;

    typedef struct packed {
        t_scheme    scheme;
        t_dir       direction;
        logic [7:0] block_size;
    } t_cfg;

    typedef struct packed {
        logic       has_result;
        logic [7:0] out_byte;
        logic [7:0] data_length;
        logic       pad_bad;
        logic       block_end;
    } t_result;

endpackage

>>> rtl/block_padding_engine.sv
// Path: a byte accepted is held in the input register; its result then goes to the
//   result register. Throughput: one byte per cycle unless an untaken result stalls it.
// Unpad mode gives a result only for the final byte.
// Reset (synchronous, active low) clears both valid flags and the running counters,
//   and sets scheme PKCS7, pad direction and block size 16.
module block_padding_engine
    import bpe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic [7:0]  i_pad_start,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic [7:0]  o_data_length,
    output logic        o_pad_bad,
    output logic        o_block_end
);

    t_cfg       cfg;
    t_result    res;
    logic       r_in_valid, r_out_valid;
    logic [7:0] r_data, r_start;
    t_result    r_res;
    logic       adv;

    bpe_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bpe_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_fire  (adv),
        .i_data  (r_data),
        .i_start (r_start),
        .o_res   (res)
    );

    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_data  <= i_data_byte;
            r_start <= i_pad_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && res.has_result) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && res.has_result) begin
            r_res <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_res.out_byte;
    assign o_data_length = r_res.data_length;
    assign o_pad_bad     = r_res.pad_bad;
    assign o_block_end   = r_res.block_end;

    a_unpad_only_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_block_end) |-> cfg.direction == DIR_PAD)
        else $error("unpad result before final byte");

    a_unpad_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && cfg.direction == DIR_UNPAD) |-> o_out_byte == 8'd0)
        else $error("unpad result carries a data byte");

    a_bad_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_pad_bad && cfg.direction == DIR_UNPAD)
        |-> o_data_length == cfg.block_size)
        else $error("bad padding length not block size");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !adv) |=> (r_in_valid && $stable(r_data)))
        else $error("stalled transaction lost");

endmodule

>>> rtl/bpe_cfg.sv
module bpe_cfg
    import bpe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg   r_cfg;
    logic   wr_en;
    t_reg_idx idx;

    assign wr_en  = psel && penable && pwrite;
    assign idx    = t_reg_idx'(paddr[3:2]);
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scheme     <= SCH_PKCS7;
            r_cfg.direction  <= DIR_PAD;
            r_cfg.block_size <= BLOCK_SIZE_RST;
        end else if (wr_en) begin
            unique case (idx)
                REG_SCHEME:     r_cfg.scheme     <= t_scheme'(pwdata[1:0]);
                REG_DIRECTION:  r_cfg.direction  <= t_dir'(pwdata[0]);
                REG_BLOCK_SIZE: r_cfg.block_size <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_SCHEME:     prdata = {30'd0, r_cfg.scheme};
            REG_DIRECTION:  prdata = {31'd0, r_cfg.direction};
            REG_BLOCK_SIZE: prdata = {24'd0, r_cfg.block_size};
            default:        prdata = 32'd0;
        endcase
    end

endmodule

>>> rtl/bpe_core.sv
module bpe_core
    import bpe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_fire,
    input  logic [7:0] i_data,
    input  logic [7:0] i_start,
    output t_result    o_res
);

    logic [7:0] r_pos, r_prev, r_equal, r_zero, r_inc, r_lnz_pos, r_lnz_val;
    logic       r_seen;
    logic [7:0] n_pos, n_equal, n_zero, n_inc, n_lnz_pos, n_lnz_val;
    logic       n_seen;

    logic       first, final_b, small_blk, d_zero;
    logic [7:0] zero_before, d_minus1, pad_len, pad_out, bs;
    logic       pad_bad_p, unpad_bad;
    logic [7:0] unpad_len;

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        sat_inc = (v == 8'hFF) ? 8'hFF : v + 8'd1;
    endfunction

    always_comb begin
        bs          = i_cfg.block_size;
        first       = (r_pos == 8'd0);
        final_b     = ({1'b0, r_pos} + 9'd1) >= {1'b0, bs};
        small_blk   = bs < MIN_BLOCK;
        d_zero      = (i_data == 8'd0);
        d_minus1    = i_data - ONE_BYTE;
        zero_before = first ? 8'd0 : r_zero;

        n_equal = (!first && i_data == r_prev) ? sat_inc(r_equal) : ONE_BYTE;
        n_zero  = d_zero ? sat_inc(zero_before) : 8'd0;
        n_inc   = (!first && !d_zero && r_prev == d_minus1) ? sat_inc(r_inc) : ONE_BYTE;
        n_seen    = d_zero ? (first ? 1'b0 : r_seen) : 1'b1;
        n_lnz_pos = d_zero ? r_lnz_pos : r_pos;
        n_lnz_val = d_zero ? r_lnz_val : i_data;
        n_pos     = final_b ? 8'd0 : r_pos + 8'd1;

        // pad direction
        pad_bad_p = (i_start >= bs) || small_blk;
        pad_len   = bs - i_start;
        unique case (i_cfg.scheme)
            SCH_PKCS7: pad_out = (r_pos >= i_start) ? pad_len : i_data;
            SCH_X923:  pad_out = final_b ? pad_len : ((r_pos >= i_start) ? 8'd0 : i_data);
            SCH_ISO:   pad_out = (r_pos == i_start) ? MARK_BYTE :
                                 ((r_pos > i_start) ? 8'd0 : i_data);
            SCH_ESP:   pad_out = (r_pos >= i_start) ? (r_pos - i_start + ONE_BYTE) : i_data;
            default:   pad_out = i_data;
        endcase

        // unpad direction
        unpad_len = bs - i_data;
        if (small_blk) begin
            unpad_bad = 1'b1;
        end else if (i_cfg.scheme == SCH_ISO) begin
            unpad_bad = !(n_seen && n_lnz_val == MARK_BYTE);
            unpad_len = n_lnz_pos;
        end else if (d_zero || i_data > bs) begin
            unpad_bad = 1'b1;
        end else begin
            unique case (i_cfg.scheme)
                SCH_PKCS7: unpad_bad = n_equal < i_data;
                SCH_X923:  unpad_bad = zero_before < d_minus1;
                default:   unpad_bad = n_inc < i_data;
            endcase
        end

        if (i_cfg.direction == DIR_PAD) begin
            o_res.has_result  = 1'b1;
            o_res.out_byte    = pad_bad_p ? i_data : pad_out;
            o_res.data_length = 8'd0;
            o_res.pad_bad     = pad_bad_p;
        end else begin
            o_res.has_result  = final_b;
            o_res.out_byte    = 8'd0;
            o_res.data_length = unpad_bad ? bs : unpad_len;
            o_res.pad_bad     = unpad_bad;
        end
        o_res.block_end = final_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= 8'd0;
            r_prev    <= 8'd0;
            r_equal   <= 8'd0;
            r_zero    <= 8'd0;
            r_inc     <= 8'd0;
            r_lnz_pos <= 8'd0;
            r_lnz_val <= 8'd0;
            r_seen    <= 1'b0;
        end else if (i_fire) begin
            r_pos     <= n_pos;
            r_prev    <= i_data;
            r_equal   <= n_equal;
            r_zero    <= n_zero;
            r_inc     <= n_inc;
            r_lnz_pos <= n_lnz_pos;
            r_lnz_val <= n_lnz_val;
            r_seen    <= n_seen;
        end
    end

endmodule

>>> bench/block_padding_engine_tb.sv
`timescale 1ns / 1ps

module block_padding_engine_tb;
    import bpe_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int TIMEOUT_CYCLES = 250000;
    localparam int SEGMENTS       = 24;
    localparam int STALL_CYCLES   = 48;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [7:0] data_length;
        logic       pad_bad;
        logic       block_end;
    } t_pad_result;

    typedef struct packed {
        t_scheme     scheme;
        t_dir        dir;
        logic [7:0]  bsize;
        logic [7:0]  data;
        logic [7:0]  start;
        logic        typed;
        t_pad_result res;
    } t_directed_row;

    localparam t_directed_row DIRECTED_ROWS [26] = '{
        '{SCH_PKCS7, DIR_PAD,   8'd16, 8'hFF, 8'hFF, 1'b1, '{8'hFF, 8'h00, 1'b1, 1'b0}},
        '{SCH_PKCS7, DIR_PAD,   8'd2,  8'h00, 8'h00, 1'b1, '{8'h00, 8'h00, 1'b1, 1'b1}},
        '{SCH_PKCS7, DIR_PAD,   8'd3,  8'h11, 8'h01, 1'b1, '{8'h11, 8'h00, 1'b0, 1'b0}},
        '{SCH_PKCS7, DIR_PAD,   8'd3,  8'h22, 8'h01, 1'b1, '{8'h02, 8'h00, 1'b0, 1'b0}},
        '{SCH_PKCS7, DIR_PAD,   8'd3,  8'h33, 8'h01, 1'b1, '{8'h02, 8'h00, 1'b0, 1'b1}},
        '{SCH_X923,  DIR_PAD,   8'd3,  8'hAA, 8'h01, 1'b1, '{8'hAA, 8'h00, 1'b0, 1'b0}},
        '{SCH_X923,  DIR_PAD,   8'd3,  8'hBB, 8'h01, 1'b1, '{8'h00, 8'h00, 1'b0, 1'b0}},
        '{SCH_X923,  DIR_PAD,   8'd3,  8'hCC, 8'h01, 1'b1, '{8'h02, 8'h00, 1'b0, 1'b1}},
        '{SCH_ISO,   DIR_PAD,   8'd3,  8'h55, 8'h01, 1'b1, '{8'h55, 8'h00, 1'b0, 1'b0}},
        '{SCH_ISO,   DIR_PAD,   8'd3,  8'h66, 8'h01, 1'b1, '{8'h80, 8'h00, 1'b0, 1'b0}},
        '{SCH_ISO,   DIR_PAD,   8'd3,  8'h77, 8'h01, 1'b1, '{8'h00, 8'h00, 1'b0, 1'b1}},
        '{SCH_ESP,   DIR_PAD,   8'd3,  8'h09, 8'h00, 1'b1, '{8'h01, 8'h00, 1'b0, 1'b0}},
        '{SCH_ESP,   DIR_PAD,   8'd3,  8'h09, 8'h00, 1'b1, '{8'h02, 8'h00, 1'b0, 1'b0}},
        '{SCH_ESP,   DIR_PAD,   8'd3,  8'h09, 8'h00, 1'b1, '{8'h03, 8'h00, 1'b0, 1'b1}},
        '{SCH_PKCS7, DIR_UNPAD, 8'd3,  8'h41, 8'h00, 1'b0, '0},
        '{SCH_PKCS7, DIR_UNPAD, 8'd3,  8'h04, 8'h00, 1'b0, '0},
        '{SCH_PKCS7, DIR_UNPAD, 8'd3,  8'h04, 8'h00, 1'b1, '{8'h00, 8'h03, 1'b1, 1'b1}},
        '{SCH_X923,  DIR_UNPAD, 8'd3,  8'h41, 8'h00, 1'b0, '0},
        '{SCH_X923,  DIR_UNPAD, 8'd3,  8'h00, 8'h00, 1'b0, '0},
        '{SCH_X923,  DIR_UNPAD, 8'd3,  8'h02, 8'h00, 1'b1, '{8'h00, 8'h01, 1'b0, 1'b1}},
        '{SCH_ISO,   DIR_UNPAD, 8'd3,  8'h80, 8'h00, 1'b0, '0},
        '{SCH_ISO,   DIR_UNPAD, 8'd3,  8'h00, 8'h00, 1'b0, '0},
        '{SCH_ISO,   DIR_UNPAD, 8'd3,  8'h00, 8'h00, 1'b1, '{8'h00, 8'h00, 1'b0, 1'b1}},
        '{SCH_ESP,   DIR_UNPAD, 8'd3,  8'h01, 8'h00, 1'b0, '0},
        '{SCH_ESP,   DIR_UNPAD, 8'd3,  8'h02, 8'h00, 1'b0, '0},
        '{SCH_ESP,   DIR_UNPAD, 8'd3,  8'h03, 8'h00, 1'b1, '{8'h00, 8'h00, 1'b0, 1'b1}}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_data_byte;
    logic [7:0]  i_pad_start;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [7:0]  o_out_byte;
    logic [7:0]  o_data_length;
    logic        o_pad_bad;
    logic        o_block_end;

    // settings as the block holds them
    t_scheme    cfg_scheme     = SCH_PKCS7;
    t_dir       cfg_dir        = DIR_PAD;
    logic [7:0] cfg_block_size = BLOCK_SIZE_RST;

    // running block state
    logic [7:0] pos_q       = '0;
    logic [7:0] prev_byte_q = '0;
    logic [7:0] equal_run_q = '0;
    logic [7:0] zero_run_q  = '0;
    logic [7:0] inc_run_q   = '0;
    logic [7:0] nz_pos_q    = '0;
    logic [7:0] nz_val_q    = '0;
    logic       seen_nz_q   = 1'b0;

    t_pad_result awaited_results [$];
    logic        item_is_typed;
    t_pad_result item_typed_result;
    int          idle_phase;
    int          fail_count = 0;
    bit          stall_done = 1'b0;

    block_padding_engine DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_data_byte   (i_data_byte),
        .i_pad_start   (i_pad_start),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_data_length (o_data_length),
        .o_pad_bad     (o_pad_bad),
        .o_block_end   (o_block_end)
    );

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    function automatic logic [7:0] sat_bump(input logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    // Advances the block state by one byte; returns 1 when the byte yields a result.
    function automatic bit predict_padding(input logic [7:0] d, input logic [7:0] st,
                                           output t_pad_result r);
        logic [7:0] at;
        logic [7:0] zero_prior;
        logic [7:0] fill;
        logic [7:0] len;
        bit         first;
        bit         last;
        bit         bad;
        at         = pos_q;
        first      = (at == 8'd0);
        last       = (9'(at) + 9'd1 >= 9'(cfg_block_size));
        zero_prior = first ? 8'd0 : zero_run_q;
        equal_run_q = (!first && d == prev_byte_q) ? sat_bump(equal_run_q) : 8'd1;
        zero_run_q  = (d == 8'd0) ? sat_bump(zero_prior) : 8'd0;
        inc_run_q   = (!first && d != 8'd0 && prev_byte_q == d - 8'd1)
                      ? sat_bump(inc_run_q) : 8'd1;
        if (first) begin
            seen_nz_q = 1'b0;
        end
        if (d != 8'd0) begin
            nz_pos_q  = at;
            nz_val_q  = d;
            seen_nz_q = 1'b1;
        end
        prev_byte_q = d;
        pos_q       = last ? 8'd0 : at + 8'd1;
        r           = '0;

        if (cfg_dir == DIR_PAD) begin
            bad  = (st >= cfg_block_size) || (cfg_block_size < MIN_BLOCK);
            fill = cfg_block_size - st;
            if (bad) begin
                r.out_byte = d;
            end else begin
                case (cfg_scheme)
                    SCH_PKCS7: r.out_byte = (at >= st) ? fill : d;
                    SCH_X923:  r.out_byte = last ? fill : ((at >= st) ? 8'h00 : d);
                    SCH_ISO:   r.out_byte = (at == st) ? MARK_BYTE
                                            : ((at > st) ? 8'h00 : d);
                    default:   r.out_byte = (at >= st) ? at - st + ONE_BYTE : d;
                endcase
            end
            r.pad_bad   = bad;
            r.block_end = last;
            return 1'b1;
        end

        if (!last) begin
            return 1'b0;
        end
        len = 8'd0;
        if (cfg_block_size < MIN_BLOCK) begin
            bad = 1'b1;
        end else if (cfg_scheme == SCH_ISO) begin
            bad = !(seen_nz_q && nz_val_q == MARK_BYTE);
            len = nz_pos_q;
        end else begin
            bad = (d == 8'd0) || (d > cfg_block_size);
            if (!bad) begin
                case (cfg_scheme)
                    SCH_PKCS7: bad = equal_run_q < d;
                    SCH_X923:  bad = zero_prior < d - 8'd1;
                    default:   bad = inc_run_q < d;
                endcase
            end
            len = cfg_block_size - d;
        end
        r.data_length = bad ? cfg_block_size : len;
        r.pad_bad     = bad;
        r.block_end   = 1'b1;
        return 1'b1;
    endfunction

    task automatic check_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $display("%0t %s mismatch: expected %0h, got %0h", $time, what, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_pad_result got;
        t_pad_result want;
        t_pad_result calc;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got = '{o_out_byte, o_data_length, o_pad_bad, o_block_end};
                if (awaited_results.size() == 0) begin
                    $display("%0t unexpected result: expected none, got %0h %0h %0b %0b",
                             $time, got.out_byte, got.data_length, got.pad_bad,
                             got.block_end);
                    fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("out_byte", want.out_byte, got.out_byte);
                    check_field("data_length", want.data_length, got.data_length);
                    check_field("pad_bad", 8'(want.pad_bad), 8'(got.pad_bad));
                    check_field("block_end", 8'(want.block_end), 8'(got.block_end));
                end
            end
            if (i_in_valid && o_in_ready) begin
                if (predict_padding(i_data_byte, i_pad_start, calc)) begin
                    awaited_results.push_back(item_is_typed ? item_typed_result : calc);
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] d, input logic [7:0] st,
                             input logic typed, input t_pad_result typed_res);
        int gap_pct;
        gap_pct = (idle_phase == 0) ? 37 : ((idle_phase == 1) ? 82 : 0);
        @(negedge i_clk);
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_data_byte       <= d;
        i_pad_start       <= st;
        item_is_typed     <= typed;
        item_typed_result <= typed_res;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_SCHEME:    cfg_scheme = t_scheme'(val[1:0]);
            REG_DIRECTION: cfg_dir = t_dir'(val[0]);
            default:       cfg_block_size = val[7:0];
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Drain the block, let the pipeline empty, then write what changed.
    task automatic settle_then_configure(input t_scheme sch, input t_dir dir,
                                         input logic [7:0] bs);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
        if (sch != cfg_scheme) write_reg(REG_SCHEME, 32'(sch));
        if (dir != cfg_dir) write_reg(REG_DIRECTION, 32'(dir));
        if (bs != cfg_block_size) write_reg(REG_BLOCK_SIZE, 32'(bs));
    endtask

    task automatic run_segment(input int seg);
        t_scheme    sch;
        t_dir       dir;
        logic [7:0] bs;
        logic [7:0] st;
        logic [7:0] blk [256];
        int         sent;
        int         lead;
        int         n;
        int         k;
        int         plen;
        sch = t_scheme'(seg % 4);
        dir = ((seg >> 2) & 1) ? DIR_UNPAD : DIR_PAD;
        case (seg)
            3:       bs = 8'd255;
            5:       bs = 8'd0;
            9:       bs = 8'd1;
            14:      bs = 8'd2;
            default: bs = ($urandom_range(99) < 80) ? 8'($urandom_range(3, 8))
                                                    : 8'($urandom_range(9, 40));
        endcase
        settle_then_configure(sch, dir, bs);

        // finish a block left open by the previous settings
        if (pos_q == 8'd0) begin
            lead = 0;
        end else if (int'(pos_q) + 1 >= int'(bs)) begin
            lead = 1;
        end else begin
            lead = int'(bs) - int'(pos_q);
        end
        repeat (lead) send_byte(8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0, '0);
        sent = lead;

        while (sent < 14) begin
            n = (bs == 8'd0) ? 1 : ((bs > 8'd40) ? 24 : int'(bs));
            for (k = 0; k < n; k++) begin
                blk[k] = 8'($urandom_range(255));
            end
            if (cfg_dir == DIR_UNPAD && bs >= MIN_BLOCK && n == int'(bs)) begin
                if ($urandom_range(99) < 75) begin
                    plen = $urandom_range(1, n);
                    for (k = n - plen; k < n; k++) begin
                        case (cfg_scheme)
                            SCH_PKCS7: blk[k] = 8'(plen);
                            SCH_X923:  blk[k] = (k == n - 1) ? 8'(plen) : 8'h00;
                            SCH_ISO:   blk[k] = (k == n - plen) ? MARK_BYTE : 8'h00;
                            default:   blk[k] = 8'(k - (n - plen) + 1);
                        endcase
                    end
                    if ($urandom_range(99) < 15) begin
                        k = $urandom_range(n - 1);
                        blk[k] = blk[k] ^ 8'(1 << $urandom_range(7));
                    end
                end else if ($urandom_range(1) == 0) begin
                    blk[n - 1] = 8'h00;
                end
            end
            st = (bs != 8'd0 && $urandom_range(99) < 85) ? 8'($urandom_range(int'(bs) - 1))
                                                         : 8'($urandom_range(255));
            for (k = 0; k < n; k++) begin
                send_byte(blk[k], st, 1'b0, '0);
            end
            sent += n;
        end
    endtask

    // result side: random back-pressure plus one long hold-off to back up the input
    initial begin
        int gap_pct;
        forever begin
            @(negedge i_clk);
            if (idle_phase == 2 && !stall_done && i_in_valid && cfg_dir == DIR_PAD) begin
                stall_done = 1'b1;
                i_out_ready <= 1'b0;
                repeat (STALL_CYCLES) @(negedge i_clk);
            end
            gap_pct = (idle_phase == 0) ? 82 : ((idle_phase == 1) ? 37 : 0);
            i_out_ready <= ($urandom_range(99) >= gap_pct);
        end
    end

    initial begin
        t_directed_row row;
        int            seg;
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        i_in_valid        = 1'b0;
        i_data_byte       = '0;
        i_pad_start       = '0;
        i_out_ready       = 1'b0;
        item_is_typed     = 1'b0;
        item_typed_result = '0;
        idle_phase        = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < $size(DIRECTED_ROWS); k++) begin
            row = DIRECTED_ROWS[k];
            if (row.scheme != cfg_scheme || row.dir != cfg_dir ||
                row.bsize != cfg_block_size) begin
                settle_then_configure(row.scheme, row.dir, row.bsize);
            end
            send_byte(row.data, row.start, row.typed, row.res);
        end

        for (seg = 0; seg < SEGMENTS; seg++) begin
            idle_phase = seg / 8;
            run_segment(seg);
        end

        settle_then_configure(cfg_scheme, cfg_dir, cfg_block_size);
        if (fail_count == 0) begin
            $display("block_padding_engine_tb passed");
        end else begin
            $display("block_padding_engine_tb failed");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("block_padding_engine_tb failed");
        $finish;
    end

endmodule

>>> block_padding_engine.f
rtl/bpe_pkg.sv
rtl/bpe_cfg.sv
rtl/bpe_core.sv
rtl/block_padding_engine.sv
bench/block_padding_engine_tb.sv
